// ===== design/nlr_pkg.sv =====
// Shared types, constants and codes of the naive line rasterizer.
`default_nettype none

package nlr_pkg;

   localparam int COORD_BITS          = 12;
   localparam int DELTA_BITS          = COORD_BITS + 1;
   localparam int ACC_BITS            = COORD_BITS + 2;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_VERT  = 2'd0,
      MODE_HORZ  = 2'd1,
      MODE_SLOPE = 2'd2
   } mode_type;

   typedef enum logic {
      BK_RUN    = 1'b0,
      BK_DIVIDE = 1'b1
   } bk_state_type;

   typedef struct packed {
      logic                         opcode;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic                         last_pixel;
   } rsp_type;

   typedef struct packed {
      logic                         is_load;
      mode_type                     mode;
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic                         neg_x;
      logic                         neg_y;
      logic [COORD_BITS-1:0]        abs_dx;
      logic [COORD_BITS-1:0]        abs_dy;
      logic [DELTA_BITS-1:0]        total;
   } cmd_type;

   typedef struct packed {
      logic dividing;
      logic line_active;
   } bk_stat_type;

endpackage

`default_nettype wire

// ===== design/naive_line_rasterizer.sv =====
// Naive line rasterizer: top level with front end, command queue and back end.
//
// Request beats on req_* carry a load (new endpoints, drops any line in
// progress) or a step (next pixel of the active line). Response beats on
// rsp_* carry one pixel with last_pixel set on the final pixel of the line.
// Loads and steps with no active line give no response beat.
// A step beat passes through the command queue and then the result register, which
// drives rsp_valid; steps go through at one per cycle while rsp_ready keeps up and
// no sloped line is being set up. Loads of vertical and horizontal lines skip the
// divide state; a load of a sloped line holds the back end in it while the radix-2
// divider forms the per-pixel y increment, and requests keep queueing meanwhile.
// The command queue holds QUEUE_DEPTH beats; req_ready drops when it fills.
// When rsp_ready is low the result register holds its pixel; the back end
// keeps taking loads and dropped steps, and the queue absorbs further beats.
// Synchronous reset empties the queue and the result register and leaves
// no line active.
`default_nettype none

module naive_line_rasterizer import nlr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_valid;
   cmd_type     q_cmd;
   cmd_type     q_head;
   bk_stat_type bk_stat;

   nlr_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   nlr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   nlr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .bk_stat   (bk_stat)
   );

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset) bk_stat.dividing |-> !q_pop)
      else $error("queue popped during slope setup");

   assert property (@(posedge clock) disable iff (reset)
      q_pop && q_head.is_load && !rsp_valid |=> !rsp_valid)
      else $error("load produced a response beat");

   assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_head.is_load && !bk_stat.line_active && !rsp_valid |=> !rsp_valid)
      else $error("step with no active line produced a response beat");

endmodule

`default_nettype wire

// ===== design/nlr_front.sv =====
// Front end: accepts request beats and classifies loads into line modes.
`default_nettype none

module nlr_front import nlr_pkg::*; (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic signed [DELTA_BITS-1:0] dx;
   logic signed [DELTA_BITS-1:0] dy;
   logic [DELTA_BITS-1:0]        dx_mag;
   logic [DELTA_BITS-1:0]        dy_mag;
   logic [COORD_BITS-1:0]        adx;
   logic [COORD_BITS-1:0]        ady;

   assign dx = {req_data.x_end[COORD_BITS-1], req_data.x_end}
             - {req_data.x_start[COORD_BITS-1], req_data.x_start};
   assign dy = {req_data.y_end[COORD_BITS-1], req_data.y_end}
             - {req_data.y_start[COORD_BITS-1], req_data.y_start};

   assign dx_mag = dx[DELTA_BITS-1] ? -dx : dx;
   assign dy_mag = dy[DELTA_BITS-1] ? -dy : dy;
   assign adx    = dx_mag[COORD_BITS-1:0];
   assign ady    = dy_mag[COORD_BITS-1:0];

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.is_load  = (req_data.opcode == OP_LOAD);
      q_cmd.origin_x = req_data.x_start;
      q_cmd.origin_y = req_data.y_start;
      q_cmd.neg_x    = dx[DELTA_BITS-1];
      q_cmd.neg_y    = dy[DELTA_BITS-1];
      q_cmd.abs_dx   = adx;
      q_cmd.abs_dy   = ady;
      if (dx == '0) begin
         q_cmd.mode  = MODE_VERT;
         q_cmd.total = DELTA_BITS'(ady) + DELTA_BITS'(1);
      end else if (dy == '0) begin
         q_cmd.mode  = MODE_HORZ;
         q_cmd.total = DELTA_BITS'(adx) + DELTA_BITS'(1);
      end else begin
         q_cmd.mode  = MODE_SLOPE;
         q_cmd.total = DELTA_BITS'(adx);
      end
   end

endmodule

`default_nettype wire

// ===== design/nlr_queue.sv =====
// Command queue between the front end and the back end.
`default_nettype none

module nlr_queue import nlr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type               mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/nlr_div.sv =====
// Radix-2 restoring divider for the slope step, one quotient bit per cycle.
`default_nettype none

module nlr_div import nlr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0] divisor,
   output logic                  done,
   output logic [COORD_BITS-1:0] quotient,
   output logic [COORD_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(COORD_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   trial_diff;
   logic                  fits;

   assign trial      = {rem_ff, quo_ff[COORD_BITS-1]};
   assign fits       = (trial >= {1'b0, dvs_ff});
   assign trial_diff = trial - {1'b0, dvs_ff};

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[COORD_BITS-2:0], fits};
         rem_in   = fits ? trial_diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == CNT_BITS'(COORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

endmodule

`default_nettype wire

// ===== design/nlr_back.sv =====
// Back end: sets up lines, walks them one pixel per beat and holds the result register.
`default_nettype none

module nlr_back import nlr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output bk_stat_type bk_stat
);

   bk_state_type                state_ff, state_in;
   logic                        active_ff, active_in;
   mode_type                    mode_ff, mode_in;
   logic                        neg_x_ff, neg_x_in;
   logic                        neg_y_ff, neg_y_in;
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]       cur_y_ff, cur_y_in;
   logic [DELTA_BITS-1:0]       index_ff, index_in;
   logic [DELTA_BITS-1:0]       total_ff, total_in;
   logic signed [ACC_BITS-1:0]  q_ff, q_in;
   logic [ACC_BITS-1:0]         r_ff, r_in;
   logic [DELTA_BITS-1:0]       den_ff, den_in;
   logic signed [ACC_BITS-1:0]  inc_q_ff, inc_q_in;
   logic [DELTA_BITS-1:0]       inc_r_ff, inc_r_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic                        div_start;
   logic                        div_done;
   logic [COORD_BITS-1:0]       div_quo;
   logic [COORD_BITS-1:0]       div_rem;
   logic [COORD_BITS-1:0]       abs_dx;

   logic                        can_emit;
   logic                        last;
   logic [ACC_BITS-1:0]         py_slope;
   logic [COORD_BITS-1:0]       x_stepped;
   logic [COORD_BITS-1:0]       y_stepped;
   logic [ACC_BITS-1:0]         r_sum;
   logic                        r_wrap;
   logic [ACC_BITS-1:0]         q_stepped;

   nlr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (q_head.abs_dy),
      .divisor   (q_head.abs_dx),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign abs_dx    = den_ff[DELTA_BITS-1:1];
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign last      = (ACC_BITS'(index_ff) + ACC_BITS'(1)) >= ACC_BITS'(total_ff);
   assign py_slope  = q_ff + ACC_BITS'(q_ff[ACC_BITS-1] && (r_ff != '0));
   assign x_stepped = neg_x_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
   assign y_stepped = neg_y_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
   assign r_sum     = r_ff + ACC_BITS'(inc_r_ff);
   assign r_wrap    = (r_sum >= ACC_BITS'(den_ff));
   assign q_stepped = q_ff + inc_q_ff + ACC_BITS'(r_wrap);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign bk_stat.dividing    = (state_ff == BK_DIVIDE);
   assign bk_stat.line_active = active_ff;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      mode_in      = mode_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      index_in     = index_ff;
      total_in     = total_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      den_in       = den_ff;
      inc_q_in     = inc_q_ff;
      inc_r_in     = inc_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         BK_RUN: begin
            if (q_valid) begin
               if (q_head.is_load) begin
                  q_pop     = 1'b1;
                  active_in = 1'b1;
                  mode_in   = q_head.mode;
                  neg_x_in  = q_head.neg_x;
                  neg_y_in  = q_head.neg_y;
                  cur_x_in  = q_head.origin_x;
                  cur_y_in  = q_head.origin_y;
                  index_in  = '0;
                  total_in  = q_head.total;
                  q_in      = {{(ACC_BITS - COORD_BITS){q_head.origin_y[COORD_BITS-1]}},
                               q_head.origin_y};
                  r_in      = ACC_BITS'(q_head.abs_dx);
                  den_in    = {q_head.abs_dx, 1'b0};
                  if (q_head.mode == MODE_SLOPE) begin
                     div_start = 1'b1;
                     state_in  = BK_DIVIDE;
                  end
               end else if (!active_ff) begin
                  q_pop = 1'b1;
               end else if (can_emit) begin
                  q_pop                  = 1'b1;
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.pixel_x    = cur_x_ff;
                  rsp_data_in.pixel_y    = cur_y_ff;
                  rsp_data_in.last_pixel = last;
                  index_in               = index_ff + DELTA_BITS'(1);
                  if (last) begin
                     active_in = 1'b0;
                  end
                  unique case (mode_ff)
                     MODE_VERT: begin
                        cur_y_in = y_stepped;
                     end
                     MODE_HORZ: begin
                        cur_x_in = x_stepped;
                     end
                     MODE_SLOPE: begin
                        rsp_data_in.pixel_y = py_slope[COORD_BITS-1:0];
                        cur_x_in            = x_stepped;
                        q_in                = q_stepped;
                        r_in                = r_wrap ? r_sum - ACC_BITS'(den_ff) : r_sum;
                     end
                     default: begin
                        cur_x_in = cur_x_ff;
                     end
                  endcase
               end
            end
         end
         BK_DIVIDE: begin
            if (div_done) begin
               state_in = BK_RUN;
               if (!neg_y_ff) begin
                  inc_q_in = ACC_BITS'(div_quo);
                  inc_r_in = {div_rem, 1'b0};
               end else if (div_rem == '0) begin
                  inc_q_in = -(ACC_BITS'(div_quo));
                  inc_r_in = '0;
               end else begin
                  inc_q_in = ~(ACC_BITS'(div_quo));
                  inc_r_in = {abs_dx - div_rem, 1'b0};
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      index_ff    <= index_in;
      total_ff    <= total_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      den_ff      <= den_in;
      inc_q_ff    <= inc_q_in;
      inc_r_ff    <= inc_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
